[design/assert_macros.svh]
// Assertion macros shared by the blur datapath modules.
// No dependencies; include by bare file name where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define BB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/bb3g_pkg.sv]
// Shared constants, types and arithmetic helpers for the 3x3 gray box blur.
// No dependencies; imported by bb3g_stream_if, box_blur_3x3_gray, bb3g_cell and bb3g_out_fifo.
`timescale 1ns / 1ps

package bb3g_pkg;

   // Register and field widths
   localparam int CFG_W        = 11;
   localparam int PIX_W        = 8;
   localparam int SUM3_W       = 10;   // red + green + blue, or one column sum
   localparam int SUM_W        = 12;   // nine gray values
   localparam int CSR_IDX_W    = 1;

   // Frame geometry
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int FRAME_RST     = 4;

   // Reciprocal constants: x/3 for x <= 765, x/9 for x <= 2295
   localparam int GRAY_RECIP   = 683;
   localparam int GRAY_SHIFT   = 11;
   localparam int DIV9_RECIP   = 3641;
   localparam int DIV9_SHIFT   = 15;

   // Output queue
   localparam int OQ_DEPTH     = 4;
   localparam int OQ_CW        = $clog2(OQ_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;

   // One window column: top row first
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } pix_col_type;

   typedef struct packed {
      logic shift;     // take a new column this cycle
      logic zero_in;   // take zeros instead of the neighbor's column
      logic clear;     // return to the reset state
   } cell_ctrl_type;

   typedef struct packed {
      pix_type blurred;
      logic    frame_last;
   } rsp_item_type;

   // Truncated mean of the three channels
   function automatic pix_type gray_of(input logic [SUM3_W-1:0] sum3);
      logic [2*SUM3_W-1:0] prod;
      prod = {{SUM3_W{1'b0}}, sum3} * (2*SUM3_W)'(GRAY_RECIP);
      return prod[GRAY_SHIFT +: PIX_W];
   endfunction

   // Sum of the three values of one column
   function automatic logic [SUM3_W-1:0] col_sum(input pix_col_type col);
      return SUM3_W'(col.top) + SUM3_W'(col.mid) + SUM3_W'(col.bot);
   endfunction

   // Truncated window sum / 9; the result never exceeds 255
   function automatic pix_type div9(input logic [SUM_W-1:0] sum);
      logic [2*SUM_W-1:0] prod;
      prod = {{SUM_W{1'b0}}, sum} * (2*SUM_W)'(DIV9_RECIP);
      return prod[DIV9_SHIFT +: PIX_W];
   endfunction

endpackage

[design/bb3g_stream_if.sv]
// Valid/ready channel interfaces for pixel requests and blurred responses.
// Depends on bb3g_pkg for field widths.
`timescale 1ns / 1ps

interface bb3g_req_if import bb3g_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [PIX_W-1:0]  red;
   logic [PIX_W-1:0]  green;
   logic [PIX_W-1:0]  blue;

   modport source (output valid, opcode, red, green, blue, input ready);
   modport sink   (input valid, opcode, red, green, blue, output ready);
endinterface

interface bb3g_rsp_if import bb3g_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PIX_W-1:0]  blurred;
   logic              frame_last;

   modport source (output valid, blurred, frame_last, input ready);
   modport sink   (input valid, blurred, frame_last, output ready);
endinterface

[design/box_blur_3x3_gray.sv]
// 3x3 box blur on gray pixels. RGB pixels enter in raster order, one per clock
// while ready is high; each becomes gray = (r+g+b)/3 and the output pixel is the
// zero-padded 3x3 window sum / 9, truncated. The result for pixel (r,c) is produced
// by input transfer number r*W+c+W+1 (counting from 0) and leaves the response
// channel via the stage A, stage B and queue registers, so W+1 flush items drain a
// frame; frame_last marks its final pixel and the stream then restarts. Throughput
// is one transfer per cycle, set by the line-buffer RAM (one read and one write a
// cycle); a 4-entry output queue keeps requests flowing while responses wait.
// Line-buffer contents from earlier frames are masked by row, so no clearing pass
// runs after reset. A write to frame_width or frame_height restarts the stream.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module box_blur_3x3_gray import bb3g_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   bb3g_req_if.sink             req_if,
   bb3g_rsp_if.source           rsp_if,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int IC_W      = $clog2(MAX_WIDTH);
   localparam int W_W       = IC_W + 1;
   localparam int CNT_W     = W_W + CFG_W;
   localparam int USE_W     = OQ_CW + 1;
   localparam int WIDTH_RST = (FRAME_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_RST;

   // Configuration, stored already clamped
   logic [W_W-1:0]    width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [CNT_W-1:0]  total_ff;

   // Input position and output count
   logic [IC_W-1:0]   ic_ff, ic_in;
   logic [CFG_W-1:0]  ir_ff, ir_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;

   // Stage A: line-buffer read data arrives
   logic              sa_valid_ff, sa_emit_ff, sa_col0_ff, sa_last_ff;
   logic              sa_top_ok_ff, sa_mid_ok_ff;
   pix_type           sa_gray_ff;
   logic [IC_W-1:0]   sa_ic_ff;

   // Stage B: window sum registered
   logic              sb_valid_ff, sb_last_ff;
   logic [SUM_W-1:0]  sb_sum_ff;

   // Same-address bypass around the RAM
   logic              byp_valid_ff, byp_valid_in;
   logic [2*PIX_W-1:0] byp_data_ff;

   logic              req_fire;
   logic              emit_now, col0_now, row_end, last_now, data_ok;
   logic [W_W-1:0]    ic_inc;
   logic [CNT_W-1:0]  cnt_inc;
   pix_type           gray_now;
   logic [2*PIX_W-1:0] lb_rd_data, lb_data, lb_wr_data;
   pix_type           top_m, mid_m;
   pix_col_type       new_col, col_a, col_b;
   cell_ctrl_type     ctrl_a, ctrl_b;
   logic [SUM_W-1:0]  acc_a, acc_b, sa_sum;
   logic [OQ_CW-1:0]  occupancy;
   logic [USE_W-1:0]  credit_use;
   rsp_item_type      push_item;

   // Clamp and hold configuration
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en && csr_index == REG_FRAME_WIDTH) begin
         if (csr_wdata == '0) begin
            width_in = W_W'(1);
         end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
            width_in = W_W'(MAX_WIDTH);
         end else begin
            width_in = W_W'(csr_wdata);
         end
      end
      if (csr_wr_en && csr_index == REG_FRAME_HEIGHT) begin
         if (csr_wdata == '0) begin
            height_in = CFG_W'(1);
         end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
            height_in = CFG_W'(MAX_HEIGHT);
         end else begin
            height_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= W_W'(WIDTH_RST);
         height_ff <= CFG_W'(FRAME_RST);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Pixels per frame, registered from the stored configuration
   always_ff @(posedge clock) begin
      total_ff <= CNT_W'(width_ff) * CNT_W'(height_ff);
   end

   // Handshake: admit while the output queue has room for every pending result
   assign credit_use = USE_W'(occupancy) + USE_W'(sa_valid_ff && sa_emit_ff)
                     + USE_W'(sb_valid_ff);
   assign req_if.ready = (credit_use < USE_W'(OQ_DEPTH));
   assign req_fire     = req_if.valid && req_if.ready;

   // Position decode for the arriving item
   assign col0_now = (ic_ff == '0);
   assign emit_now = (ir_ff >= CFG_W'(2)) || (ir_ff == CFG_W'(1) && !col0_now);
   assign ic_inc   = W_W'(ic_ff) + W_W'(1);
   assign row_end  = (ic_inc == width_ff);
   assign cnt_inc  = out_count_ff + CNT_W'(1);
   assign last_now = emit_now && (cnt_inc == total_ff);
   assign data_ok  = (req_if.opcode == OP_PIXEL) && (ir_ff < height_ff);
   assign gray_now = data_ok ? gray_of(SUM3_W'(req_if.red) + SUM3_W'(req_if.green)
                                       + SUM3_W'(req_if.blue)) : '0;

   // Advance position; restart on frame end or register write
   always_comb begin
      ic_in        = ic_ff;
      ir_in        = ir_ff;
      out_count_in = out_count_ff;
      if (csr_wr_en) begin
         ic_in        = '0;
         ir_in        = '0;
         out_count_in = '0;
      end else if (req_fire) begin
         if (last_now) begin
            ic_in        = '0;
            ir_in        = '0;
            out_count_in = '0;
         end else begin
            ic_in = row_end ? '0 : ic_inc[IC_W-1:0];
            ir_in = row_end ? ir_ff + CFG_W'(1) : ir_ff;
            if (emit_now) begin
               out_count_in = cnt_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff        <= '0;
         ir_ff        <= '0;
         out_count_ff <= '0;
      end else begin
         ic_ff        <= ic_in;
         ir_ff        <= ir_in;
         out_count_ff <= out_count_in;
      end
   end

   // Stage A capture
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sa_emit_ff   <= emit_now;
         sa_col0_ff   <= col0_now;
         sa_last_ff   <= last_now;
         sa_top_ok_ff <= (ir_ff >= CFG_W'(2));
         sa_mid_ok_ff <= (ir_ff != '0);
         sa_gray_ff   <= gray_now;
         sa_ic_ff     <= ic_ff;
      end
   end

   // Line buffers: upper row in the high byte, middle row in the low byte
   bb3g_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (sa_valid_ff),
      .wr_addr (sa_ic_ff),
      .wr_data (lb_wr_data),
      .rd_en   (req_fire),
      .rd_addr (ic_ff),
      .rd_data (lb_rd_data)
   );

   // Catch a read that lands on the address written in the same cycle
   assign byp_valid_in = req_fire && sa_valid_ff && (ic_ff == sa_ic_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= byp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byp_valid_in) begin
         byp_data_ff <= lb_wr_data;
      end
   end

   // Rows not yet written in this frame read as padding
   assign lb_data    = byp_valid_ff ? byp_data_ff : lb_rd_data;
   assign top_m      = sa_top_ok_ff ? lb_data[2*PIX_W-1:PIX_W] : '0;
   assign mid_m      = sa_mid_ok_ff ? lb_data[PIX_W-1:0] : '0;
   assign lb_wr_data = {mid_m, sa_gray_ff};
   assign new_col    = '{top: top_m, mid: mid_m, bot: sa_gray_ff};

   // Window cells: cell A holds the older column, cell B the newer one
   assign ctrl_a = '{shift: sa_valid_ff, zero_in: sa_col0_ff,
                     clear: csr_wr_en || (sa_valid_ff && sa_last_ff)};
   assign ctrl_b = '{shift: sa_valid_ff, zero_in: 1'b0,
                     clear: csr_wr_en || (sa_valid_ff && sa_last_ff)};

   bb3g_cell u_cell_a (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl_a),
      .nb_col   (col_b),
      .out_col  (col_a),
      .acc_from ('0),
      .acc_to   (acc_a)
   );

   bb3g_cell u_cell_b (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl_b),
      .nb_col   (new_col),
      .out_col  (col_b),
      .acc_from (acc_a),
      .acc_to   (acc_b)
   );

   // At a row start the pending pixel is the last of its row: right side is padding
   assign sa_sum = acc_b + (sa_col0_ff ? '0 : SUM_W'(col_sum(new_col)));

   // Stage B capture
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else begin
         sb_valid_ff <= sa_valid_ff && sa_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sa_valid_ff && sa_emit_ff) begin
         sb_sum_ff  <= sa_sum;
         sb_last_ff <= sa_last_ff;
      end
   end

   // Divide by nine and queue the result
   assign push_item = '{blurred: div9(sb_sum_ff), frame_last: sb_last_ff};

   bb3g_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (sb_valid_ff),
      .push_data (push_item),
      .occupancy (occupancy),
      .rsp_if    (rsp_if)
   );

   `BB_ASSERT(a_credit_bound, clock, reset, credit_use <= USE_W'(OQ_DEPTH), "output credits exceeded")
   `BB_ASSERT(a_frame_restart, clock, reset, (req_fire && last_now) |=> (ic_ff == '0 && ir_ff == '0 && out_count_ff == '0), "frame end did not restart position")

endmodule

[design/bb3g_ram.sv]
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`timescale 1ns / 1ps

module bb3g_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bb3g_cell.sv]
// One window column cell: holds three gray values, hands them to its
// neighbor and adds its column sum onto the running window sum.
// Depends on bb3g_pkg.
`timescale 1ns / 1ps

module bb3g_cell import bb3g_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  pix_col_type      nb_col,
   output pix_col_type      out_col,
   input  logic [SUM_W-1:0] acc_from,
   output logic [SUM_W-1:0] acc_to
);

   pix_col_type col_ff;
   pix_col_type col_in;

   // Pick the next column: restart, row start, shift or hold
   always_comb begin
      col_in = col_ff;
      if (ctrl.clear) begin
         col_in = '0;
      end else if (ctrl.shift) begin
         col_in = ctrl.zero_in ? '0 : nb_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   // Pass the column on and grow the partial sum
   assign out_col = col_ff;
   assign acc_to  = acc_from + SUM_W'(col_sum(col_ff));

endmodule

[design/bb3g_out_fifo.sv]
// Small output queue that drives the response channel; it decouples the
// datapath from response back-pressure. Depends on bb3g_pkg, bb3g_rsp_if.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bb3g_out_fifo import bb3g_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsp_item_type       push_data,
   output logic [OQ_CW-1:0]   occupancy,
   bb3g_rsp_if.source         rsp_if
);

   localparam int PTR_W = $clog2(OQ_DEPTH);

   rsp_item_type     mem_ff [OQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OQ_CW-1:0] count_ff, count_in;
   logic             pop;

   assign rsp_if.valid      = (count_ff != '0);
   assign rsp_if.blurred    = mem_ff[rd_ptr_ff].blurred;
   assign rsp_if.frame_last = mem_ff[rd_ptr_ff].frame_last;
   assign pop               = rsp_if.valid && rsp_if.ready;
   assign occupancy         = count_ff;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BB_ASSERT(a_oq_no_overflow, clock, reset, push |-> (count_ff < OQ_CW'(OQ_DEPTH)), "output queue overflow")

endmodule
